// File: rtl/core/ndt_pkg.sv
// Shared types and constants for the network device table.
package ndt_pkg;

  // Default number of table entries
  localparam int TABLE_ENTRIES_DEF = 16;

  // Widths of the result fields
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [2:0] {
    CMD_JOIN   = 3'd0,
    CMD_LEAVE  = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_SEEN   = 3'd3,
    CMD_FORGET = 3'd4
  } command_t;

  typedef enum logic [2:0] {
    ST_SHORT    = 3'd0,
    ST_LONG     = 3'd1,
    ST_ADDED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  // One request beat
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] short_address;
    logic [63:0] long_address;
    logic [7:0]  join_endpoint;
    logic        join_kind;
  } req_t;

  // One response beat
  typedef struct packed {
    logic [2:0]           status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [7:0]           entry_endpoint;
    logic                 entry_kind;
    logic                 entry_online;
    logic [OUT_CNT_W-1:0] entry_count;
  } rsp_t;

endpackage

// File: rtl/core/network_device_table_unit.sv
// Top level of the network device table: command sequencer over a chain of entry cells.
//
// Each entry lives in its own cell. A join, leave, lookup or seen command launches a
// probe that walks the cell chain one cell per cycle; every cell below the fill count
// compares its short and long address and the probe keeps the first hit of each. When
// the probe leaves the last cell the sequencer picks the outcome, posts at most one
// write to the chosen cell and registers the response. For these commands the probe
// is held in the launch register, then in the register of each cell in turn, and the
// response is registered as the probe leaves the chain. Forget-all and unknown commands
// put up their response the cycle after the request beat. One command is in flight at a
// time; the next request is taken once the response beat has been accepted. Forget-all
// only resets the fill count.
module network_device_table_unit #(
  parameter int TABLE_ENTRIES = ndt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ndt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ndt_pkg::rsp_t rsp
);
  import ndt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic             active;
    logic [15:0]      short_address;
    logic [63:0]      long_address;
    logic [CNT_W-1:0] count;
    logic             short_hit;
    logic             long_hit;
    logic [IDX_W-1:0] short_idx;
    logic [IDX_W-1:0] long_idx;
    logic [7:0]       endpoint;
    logic             kind;
    logic             online;
  } probe_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             short_en;
    logic [15:0]      short_address;
    logic             long_en;
    logic [63:0]      long_address;
    logic             data_en;
    logic [7:0]       endpoint;
    logic             kind;
    logic             online_en;
    logic             online;
  } wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state;
  req_t             cmd;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  probe_t           launch;
  wr_t              wcmd;
  wr_t              wcmd_next;
  rsp_t             rsp_next;
  rsp_t             rsp_direct;
  probe_t           probe_bus [TABLE_ENTRIES+1];
  probe_t           exitp;

  logic             hit;
  logic             scan_cmd;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
  logic [CNT_W+OUT_CNT_W-1:0] cur_cnt_ext;

  // Chain of entry cells
  assign probe_bus[0] = launch;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ndt_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .INDEX         (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (probe_bus[i]),
      .probe_out (probe_bus[i+1]),
      .wr        (wcmd)
    );
  end

  assign exitp = probe_bus[TABLE_ENTRIES];

  // Commands that walk the chain
  assign scan_cmd = req.command inside {CMD_JOIN, CMD_LEAVE, CMD_LOOKUP, CMD_SEEN};

  // Answer forget-all and unknown commands without a probe
  assign cur_cnt_ext = {{OUT_CNT_W{1'b0}}, count};

  always_comb begin
    rsp_direct             = '0;
    rsp_direct.status      = ST_NOTFOUND;
    rsp_direct.entry_count = cur_cnt_ext[OUT_CNT_W-1:0];
    if (req.command == CMD_FORGET) begin
      rsp_direct.status      = ST_CLEARED;
      rsp_direct.entry_count = '0;
    end
  end

  // Decide outcome once the probe leaves the chain
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = ST_NOTFOUND;
    wcmd_next       = '0;
    count_next      = count;
    hit             = 1'b0;
    sel_idx         = '0;
    case (cmd.command) inside
      CMD_JOIN: begin
        if (exitp.short_hit) begin
          rsp_next.status = ST_SHORT;
          sel_idx         = exitp.short_idx;
          hit             = 1'b1;
        end else if (exitp.long_hit) begin
          rsp_next.status = ST_LONG;
          sel_idx         = exitp.long_idx;
          hit             = 1'b1;
          wcmd_next.short_en = 1'b1;
        end else if (count == CNT_W'(TABLE_ENTRIES)) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status   = ST_ADDED;
          sel_idx           = count[IDX_W-1:0];
          hit               = 1'b1;
          wcmd_next.short_en = 1'b1;
          wcmd_next.long_en  = 1'b1;
          count_next        = count + CNT_W'(1);
        end
        if (hit) begin
          wcmd_next.en            = 1'b1;
          wcmd_next.idx           = sel_idx;
          wcmd_next.short_address = cmd.short_address;
          wcmd_next.long_address  = cmd.long_address;
          wcmd_next.data_en       = 1'b1;
          wcmd_next.endpoint      = cmd.join_endpoint;
          wcmd_next.kind          = cmd.join_kind;
          wcmd_next.online_en     = 1'b1;
          wcmd_next.online        = 1'b1;
          rsp_next.entry_endpoint = cmd.join_endpoint;
          rsp_next.entry_kind     = cmd.join_kind;
          rsp_next.entry_online   = 1'b1;
        end
      end
      CMD_LEAVE, CMD_LOOKUP, CMD_SEEN: begin
        if (exitp.short_hit) begin
          rsp_next.status         = ST_SHORT;
          sel_idx                 = exitp.short_idx;
          hit                     = 1'b1;
          rsp_next.entry_endpoint = exitp.endpoint;
          rsp_next.entry_kind     = exitp.kind;
          rsp_next.entry_online   = exitp.online;
          wcmd_next.idx           = sel_idx;
          if (cmd.command == CMD_LEAVE) begin
            rsp_next.entry_online = 1'b0;
            wcmd_next.en          = 1'b1;
            wcmd_next.online_en   = 1'b1;
            wcmd_next.online      = 1'b0;
          end
          if (cmd.command == CMD_SEEN) begin
            rsp_next.entry_online = 1'b1;
            wcmd_next.en          = 1'b1;
            wcmd_next.online_en   = 1'b1;
            wcmd_next.online      = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    idx_ext = {{OUT_IDX_W{1'b0}}, sel_idx};
    cnt_ext = {{OUT_CNT_W{1'b0}}, count_next};
    if (hit) begin
      rsp_next.entry_index = idx_ext[OUT_IDX_W-1:0];
    end
    rsp_next.entry_count = cnt_ext[OUT_CNT_W-1:0];
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  // Sequencer: launch probe, take the decision, hold the response beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      launch.active <= 1'b0;
      wcmd.en       <= 1'b0;
    end else begin
      launch.active <= (state == S_IDLE) && req_valid && scan_cmd;
      wcmd.en       <= (state == S_SCAN) && exitp.active && wcmd_next.en;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd <= req;
            if (scan_cmd) begin
              state <= S_SCAN;
            end else begin
              if (req.command == CMD_FORGET) begin
                count <= '0;
              end
              rsp   <= rsp_direct;
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (exitp.active) begin
            rsp     <= rsp_next;
            count   <= count_next;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // Probe payload loads with every accepted request
    if (state == S_IDLE) begin
      launch.short_address <= req.short_address;
      launch.long_address  <= req.long_address;
      launch.count         <= count;
      launch.short_hit     <= 1'b0;
      launch.long_hit      <= 1'b0;
      launch.short_idx     <= '0;
      launch.long_idx      <= '0;
      launch.endpoint      <= '0;
      launch.kind          <= 1'b0;
      launch.online        <= 1'b0;
    end
    if (state == S_SCAN && exitp.active) begin
      wcmd.idx           <= wcmd_next.idx;
      wcmd.short_en      <= wcmd_next.short_en;
      wcmd.short_address <= wcmd_next.short_address;
      wcmd.long_en       <= wcmd_next.long_en;
      wcmd.long_address  <= wcmd_next.long_address;
      wcmd.data_en       <= wcmd_next.data_en;
      wcmd.endpoint      <= wcmd_next.endpoint;
      wcmd.kind          <= wcmd_next.kind;
      wcmd.online_en     <= wcmd_next.online_en;
      wcmd.online        <= wcmd_next.online;
    end
  end

endmodule

// File: rtl/core/ndt_cell.sv
// One table entry: compares a passing probe, records first hits, takes writes.
module ndt_cell #(
  parameter int TABLE_ENTRIES = ndt_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX         = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic [1 + 16 + 64 + ((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1) * 2
                + $clog2(TABLE_ENTRIES + 1) + 2 + 8 + 1 + 1 - 1:0] probe_in,
  output logic [1 + 16 + 64 + ((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1) * 2
                + $clog2(TABLE_ENTRIES + 1) + 2 + 8 + 1 + 1 - 1:0] probe_out,
  input  logic [1 + ((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1) + 1 + 16 + 1 + 64
                + 1 + 8 + 1 + 1 + 1 - 1:0] wr
);
  import ndt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic             active;
    logic [15:0]      short_address;
    logic [63:0]      long_address;
    logic [CNT_W-1:0] count;
    logic             short_hit;
    logic             long_hit;
    logic [IDX_W-1:0] short_idx;
    logic [IDX_W-1:0] long_idx;
    logic [7:0]       endpoint;
    logic             kind;
    logic             online;
  } probe_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             short_en;
    logic [15:0]      short_address;
    logic             long_en;
    logic [63:0]      long_address;
    logic             data_en;
    logic [7:0]       endpoint;
    logic             kind;
    logic             online_en;
    logic             online;
  } wr_t;

  probe_t pin;
  probe_t pout;
  probe_t probe_next;
  wr_t    wcmd;

  logic [15:0] short_address;
  logic [63:0] long_address;
  logic [7:0]  endpoint;
  logic        kind;
  logic        online;

  logic in_use;
  logic short_match;
  logic long_match;
  logic selected;

  assign pin       = probe_t'(probe_in);
  assign wcmd      = wr_t'(wr);
  assign probe_out = pout;

  // Compare only entries below the fill count
  assign in_use      = CNT_W'(INDEX) < pin.count;
  assign short_match = pin.active && in_use && (pin.short_address == short_address);
  assign long_match  = pin.active && in_use && (pin.long_address == long_address);

  // Record the first hit of each kind and pass the probe on
  always_comb begin
    probe_next = pin;
    if (short_match && !pin.short_hit) begin
      probe_next.short_hit = 1'b1;
      probe_next.short_idx = IDX_W'(INDEX);
      probe_next.endpoint  = endpoint;
      probe_next.kind      = kind;
      probe_next.online    = online;
    end
    if (long_match && !pin.long_hit) begin
      probe_next.long_hit = 1'b1;
      probe_next.long_idx = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.active <= 1'b0;
    end else begin
      pout.active <= probe_next.active;
    end
    pout.short_address <= probe_next.short_address;
    pout.long_address  <= probe_next.long_address;
    pout.count         <= probe_next.count;
    pout.short_hit     <= probe_next.short_hit;
    pout.long_hit      <= probe_next.long_hit;
    pout.short_idx     <= probe_next.short_idx;
    pout.long_idx      <= probe_next.long_idx;
    pout.endpoint      <= probe_next.endpoint;
    pout.kind          <= probe_next.kind;
    pout.online        <= probe_next.online;
  end

  // Take writes addressed to this entry
  assign selected = wcmd.en && (wcmd.idx == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (selected) begin
      if (wcmd.short_en) begin
        short_address <= wcmd.short_address;
      end
      if (wcmd.long_en) begin
        long_address <= wcmd.long_address;
      end
      if (wcmd.data_en) begin
        endpoint <= wcmd.endpoint;
        kind     <= wcmd.kind;
      end
      if (wcmd.online_en) begin
        online <= wcmd.online;
      end
    end
  end

endmodule

// File: rtl/core/ndt_checker.sv
// Port checker for the network device table, bound to the top level.
module ndt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ndt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ndt_pkg::rsp_t rsp
);
  import ndt_pkg::*;

  // Never take a request while a response beat is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while response pending");

  // Drop ready right after a request beat
  a_ready_drops: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready held after request beat");

  // Hold the response beat while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response changed while stalled");

  // Report no entry fields when nothing matched
  a_no_entry: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NOTFOUND ||
                   rsp.status == ST_CLEARED))
    |-> (rsp.entry_index == '0 && rsp.entry_endpoint == '0 &&
         !rsp.entry_kind && !rsp.entry_online))
    else $error("entry fields set without an entry");

  // Empty table after forget-all
  a_cleared_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_CLEARED) |-> (rsp.entry_count == '0))
    else $error("count not zero after forget-all");

endmodule

bind network_device_table_unit ndt_checker u_ndt_checker (.*);

// File: verif/tb_network_device_table_unit.sv
// Self-checking testbench for the network device table unit.
module tb_network_device_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ndt_pkg::*;

  localparam int DEPTH           = TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE       = 24;
  localparam int RANDOM_ITEMS    = 1200;
  localparam int PRESSURE_ITEMS  = 40;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 40;

  // Command codes the block does not define
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Table shadow: only entries below shadow_used are ever read
  logic [15:0] shadow_short  [DEPTH];
  logic [63:0] shadow_long   [DEPTH];
  logic [7:0]  shadow_ep     [DEPTH];
  logic        shadow_kind   [DEPTH];
  logic        shadow_online [DEPTH];
  int          shadow_used;

  // Device population that drives the traffic
  logic [15:0] pool_short [POOL_SIZE];
  logic [63:0] pool_long  [POOL_SIZE];

  rsp_t     expected_rsp_q [$];
  rsp_t     want_rsp;
  int       errors = 0;
  int       reports = 0;
  int       burst_left;
  int       idle_cycles = 0;
  int       hold_requests = 0;
  int       holds_taken = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       phase = 0;
  rx_mode_t stall_mode = RX_OPEN;

  network_device_table_unit #(
    .TABLE_ENTRIES(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t mk_req(input logic [2:0] cmd, input logic [15:0] sa,
                                  input logic [63:0] la, input logic [7:0] ep,
                                  input logic kind);
    req_t item;
    item.command       = cmd;
    item.short_address = sa;
    item.long_address  = la;
    item.join_endpoint = ep;
    item.join_kind     = kind;
    return item;
  endfunction

  function automatic int find_short(input logic [15:0] sa);
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_short[i] == sa) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the response it should produce
  function automatic rsp_t apply_table_cmd(input req_t item);
    rsp_t    res;
    status_t st;
    int      hit;
    res = '0;
    st  = ST_NOTFOUND;
    hit = -1;
    case (item.command) inside
      CMD_JOIN: begin
        hit = find_short(item.short_address);
        if (hit >= 0) begin
          st = ST_SHORT;
        end else begin
          for (int i = 0; i < shadow_used && hit < 0; i++) begin
            if (shadow_long[i] == item.long_address) hit = i;
          end
          if (hit >= 0) begin
            // rejoin under a new short address
            st = ST_LONG;
            shadow_short[hit] = item.short_address;
          end else if (shadow_used >= DEPTH) begin
            st = ST_FULL;
          end else begin
            hit = shadow_used;
            shadow_used++;
            shadow_short[hit] = item.short_address;
            shadow_long[hit]  = item.long_address;
            st = ST_ADDED;
          end
        end
        if (hit >= 0) begin
          shadow_ep[hit]     = item.join_endpoint;
          shadow_kind[hit]   = item.join_kind;
          shadow_online[hit] = 1'b1;
        end
      end
      CMD_LEAVE, CMD_LOOKUP, CMD_SEEN: begin
        hit = find_short(item.short_address);
        if (hit >= 0) begin
          st = ST_SHORT;
          if (item.command == CMD_LEAVE) shadow_online[hit] = 1'b0;
          if (item.command == CMD_SEEN) shadow_online[hit] = 1'b1;
        end
      end
      CMD_FORGET: begin
        // stale entries are rewritten before they can be read again
        shadow_used = 0;
        st = ST_CLEARED;
      end
      default: begin
      end
    endcase
    res.status = st;
    if (hit >= 0) begin
      res.entry_index    = hit[OUT_IDX_W-1:0];
      res.entry_endpoint = shadow_ep[hit];
      res.entry_kind     = shadow_kind[hit];
      res.entry_online   = shadow_online[hit];
    end
    res.entry_count = shadow_used[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Build one traffic beat, mostly about devices in the pool
  function automatic req_t make_traffic_req();
    req_t item;
    int   pick;
    int   sub;
    int   slot;
    pick = $urandom_range(0, 199);
    slot = $urandom_range(0, POOL_SIZE - 1);
    item = mk_req(CMD_JOIN, pool_short[slot], pool_long[slot], 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    if (pick < 2) begin
      item.command = CMD_FORGET;
      item.long_address = {$urandom, $urandom};
    end else if (pick < 8) begin
      item.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      item.short_address = 16'($urandom);
      item.long_address = {$urandom, $urandom};
    end else if (pick < 90) begin
      sub = $urandom_range(0, 9);
      if (sub < 3) begin
        // known device comes back under a new short address
        pool_short[slot] = 16'($urandom);
        item.short_address = pool_short[slot];
      end else if (sub < 5) begin
        // newcomer replaces a pool slot
        pool_short[slot] = 16'($urandom);
        pool_long[slot]  = {$urandom, $urandom};
        item.short_address = pool_short[slot];
        item.long_address  = pool_long[slot];
      end
    end else begin
      item.command = 3'($urandom_range(CMD_LEAVE, CMD_SEEN));
      item.long_address = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) item.short_address = 16'($urandom);
    end
    return item;
  endfunction

  // Offer one beat in sender bursts and record its expected response on acceptance
  task automatic send_cmd(input req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    expected_rsp_q.push_back(apply_table_cmd(item));
  endtask

  task automatic test_join_paths();
    send_cmd(mk_req(CMD_LOOKUP, 16'h0000, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_JOIN, 16'h0000, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_JOIN, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1));
    send_cmd(mk_req(CMD_JOIN, 16'hFFFF, 64'h5A5A_A5A5_5A5A_A5A5, 8'h3C, 1'b0));
    send_cmd(mk_req(CMD_JOIN, 16'h1234, 64'hFFFF_FFFF_FFFF_FFFF, 8'hC3, 1'b1));
  endtask

  task automatic test_entry_commands();
    send_cmd(mk_req(CMD_LEAVE, 16'h1234, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_LOOKUP, 16'h1234, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_SEEN, 16'h1234, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_SPARE_LO, 16'h0000, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_SPARE_HI, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1));
  endtask

  task automatic test_fill_and_forget();
    logic [15:0] n;
    n = 16'h0;
    while (shadow_used < DEPTH) begin
      send_cmd(mk_req(CMD_JOIN, 16'h0100 + n, 64'h0000_0001_0000_0000 + n, n[7:0], n[0]));
      n++;
    end
    // no match and no room left
    send_cmd(mk_req(CMD_JOIN, 16'h7777, 64'h0123_4567_89AB_CDEF, 8'h81, 1'b1));
    send_cmd(mk_req(CMD_FORGET, 16'h0000, 64'h0, 8'h00, 1'b0));
    send_cmd(mk_req(CMD_LOOKUP, 16'h0100, 64'h0, 8'h00, 1'b0));
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_short[i] = 16'($urandom);
      pool_long[i]  = {$urandom, $urandom};
    end
    repeat (RANDOM_ITEMS) send_cmd(make_traffic_req());
  endtask

  task automatic test_output_backpressure();
    hold_requests++;
    repeat (PRESSURE_ITEMS) send_cmd(make_traffic_req());
  endtask

  // Response side: stall patterns plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      hold_left = RSP_HOLD_CYCLES;
      holds_taken = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      case (stall_mode)
        RX_OPEN: rsp_ready <= 1'b1;
        RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
        default: rsp_ready <= ((phase % 5) < 2);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
      reports++;
    end
  endfunction

  // Compare each response beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        end
        reports++;
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        check_field("status", 8'(want_rsp.status), 8'(rsp.status));
        check_field("entry_index", 8'(want_rsp.entry_index), 8'(rsp.entry_index));
        check_field("entry_endpoint", want_rsp.entry_endpoint, rsp.entry_endpoint);
        check_field("entry_kind", 8'(want_rsp.entry_kind), 8'(rsp.entry_kind));
        check_field("entry_online", 8'(want_rsp.entry_online), 8'(rsp.entry_online));
        check_field("entry_count", 8'(want_rsp.entry_count), 8'(rsp.entry_count));
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d responses pending", $time,
                 expected_rsp_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    shadow_used  = 0;
    burst_left   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_join_paths();
    test_entry_commands();
    test_fill_and_forget();
    test_random_traffic();
    test_output_backpressure();

    // drain outstanding responses, then watch for stray beats
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ndt_pkg.sv
rtl/core/ndt_cell.sv
rtl/core/network_device_table_unit.sv
rtl/core/ndt_checker.sv
verif/tb_network_device_table_unit.sv
